>>> rtl/rtps_pkg.sv
`timescale 1ns / 1ps

package rtps_pkg;

   localparam int LEVEL_W        = 48;
   localparam int COLOR_TICKS    = 40;
   localparam int TICKS_PER_BIT  = 5;
   localparam int PAUSE_RESET    = 50;
   localparam int BYTE_W         = 8;
   localparam int PIXEL_W        = 3 * BYTE_W;

   typedef enum logic [1:0] {
      PH_PAUSE = 2'd0,
      PH_GREEN = 2'd1,
      PH_RED   = 2'd2,
      PH_BLUE  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      SEL_RED   = 2'd0,
      SEL_GREEN = 2'd1,
      SEL_BLUE  = 2'd2,
      SEL_NONE  = 2'd3
   } color_sel_type;

   typedef enum logic [1:0] {
      CSR_PAUSE_TICKS = 2'd0,
      CSR_LINE_INVERT = 2'd1
   } csr_index_type;

   // per-tick control shared by every cell
   typedef struct packed {
      logic          active;
      logic          force_hi;
      logic          force_lo;
      phase_type     color;
      logic [2:0]    bit_no;
   } slice_type;

   typedef struct packed {
      logic          en;
      logic [5:0]    index;
      color_sel_type sel;
      logic [7:0]    value;
   } pix_wr_type;

endpackage

>>> rtl/rtps_cell.sv
`timescale 1ns / 1ps

module rtps_cell #(
   parameter int CELL_ID = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rtps_pkg::pix_wr_type   pix_wr,
   input  logic                   latch,
   input  rtps_pkg::slice_type    slice,
   output logic                   level
);

   logic [rtps_pkg::PIXEL_W-1:0] staged_ff, staged_in;
   logic [rtps_pkg::PIXEL_W-1:0] latched_ff, latched_in;
   logic [rtps_pkg::BYTE_W-1:0]  color_byte;

   always_comb begin
      staged_in  = staged_ff;
      latched_in = latch ? staged_ff : latched_ff;
      if (pix_wr.en && (pix_wr.index == 6'(CELL_ID))) begin
         case (pix_wr.sel)
            rtps_pkg::SEL_RED:   staged_in[7:0]   = pix_wr.value;
            rtps_pkg::SEL_GREEN: staged_in[15:8]  = pix_wr.value;
            rtps_pkg::SEL_BLUE:  staged_in[23:16] = pix_wr.value;
            default:             staged_in        = staged_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         staged_ff  <= '0;
         latched_ff <= '0;
      end else begin
         staged_ff  <= staged_in;
         latched_ff <= latched_in;
      end
   end

   always_comb begin
      case (slice.color)
         rtps_pkg::PH_GREEN: color_byte = latched_ff[15:8];
         rtps_pkg::PH_RED:   color_byte = latched_ff[7:0];
         rtps_pkg::PH_BLUE:  color_byte = latched_ff[23:16];
         default:            color_byte = '0;
      endcase
      level = slice.active &
              (slice.force_hi | (~slice.force_lo & color_byte[slice.bit_no]));
   end

endmodule

>>> rtl/rtps_ctrl.sv
`timescale 1ns / 1ps

module rtps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick,
   input  logic [7:0]             pause_ticks,
   output logic                   latch,
   output rtps_pkg::slice_type    slice,
   output rtps_pkg::phase_type    phase
);

   rtps_pkg::phase_type phase_ff, phase_in;
   logic [7:0] count_ff, count_in;
   logic [2:0] pos_ff, pos_in;
   logic [2:0] bit_ff, bit_in;
   logic       phase_end;
   logic [2:0] pos_cur;
   logic [2:0] bit_cur;

   always_comb begin
      if (phase_ff == rtps_pkg::PH_PAUSE)
         phase_end = (count_ff == pause_ticks);
      else
         phase_end = (count_ff == 8'(rtps_pkg::COLOR_TICKS));

      phase    = phase_ff;
      count_in = count_ff;
      pos_cur  = pos_ff;
      bit_cur  = bit_ff;
      if (phase_end) begin
         phase    = rtps_pkg::phase_type'(phase_ff + 2'd1);
         count_in = '0;
         pos_cur  = '0;
         bit_cur  = '0;
      end
      latch = tick && phase_end && (phase_ff == rtps_pkg::PH_BLUE);

      slice.active   = (phase != rtps_pkg::PH_PAUSE);
      slice.force_hi = (pos_cur == 3'd0);
      slice.force_lo = (pos_cur == 3'(rtps_pkg::TICKS_PER_BIT - 1));
      slice.color    = phase;
      slice.bit_no   = bit_cur;

      phase_in = phase;
      count_in = count_in + 8'd1;
      // bit position within the phase, kept beside the tick count
      if (pos_cur == 3'(rtps_pkg::TICKS_PER_BIT - 1)) begin
         pos_in = '0;
         bit_in = bit_cur + 3'd1;
      end else begin
         pos_in = pos_cur + 3'd1;
         bit_in = bit_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rtps_pkg::PH_PAUSE;
         count_ff <= '0;
         pos_ff   <= '0;
         bit_ff   <= '0;
      end else if (tick) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         bit_ff   <= bit_in;
      end
   end

   a_color_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != rtps_pkg::PH_PAUSE) |-> (count_ff <= 8'(rtps_pkg::COLOR_TICKS)))
      else $error("tick count ran past the end of a color phase");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < 3'(rtps_pkg::TICKS_PER_BIT))
      else $error("bit position out of range");

   a_latch_blue: assert property (@(posedge clock) disable iff (reset)
      latch |=> (phase_ff == rtps_pkg::PH_PAUSE) && (count_ff == 8'd1))
      else $error("frame latch not followed by pause start");

endmodule

>>> rtl/rgb_tube_pulse_serializer.sv
`timescale 1ns / 1ps
// a tick transfer's line levels are registered and appear on rsp in the cycle after acceptance
// throughput: one item per cycle while rsp is not stalled; pixel writes give no result
// the input stalls only while a registered result is held by rsp_tready
// reset: both pixel stores cleared, pause phase with count zero,
//        pause_ticks 50 and line inversion on; no clearing pass
module rgb_tube_pulse_serializer #(
   parameter int LINES = 48
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // line_index[5:0], color_select[7:6], color_value[15:8]
   input  logic         req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // line_levels[47:0]
   output logic [1:0]   rsp_tuser,   // phase
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_data
);

   logic                 req_take;
   logic                 tick;
   rtps_pkg::pix_wr_type pix_wr;
   logic                 latch;
   rtps_pkg::slice_type  slice;
   rtps_pkg::phase_type  phase;
   logic [LINES-1:0]     cell_level;
   logic [rtps_pkg::LEVEL_W-1:0] levels;

   logic [7:0]  pause_ticks_ff;
   logic        invert_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [rtps_pkg::LEVEL_W-1:0] rsp_data_ff;
   rtps_pkg::phase_type rsp_phase_ff;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_take   = req_tvalid & req_tready;
   assign tick       = req_take & ~req_tuser;
   assign csr_ready  = 1'b1;

   assign pix_wr.en    = req_take & req_tuser;
   assign pix_wr.index = req_tdata[5:0];
   assign pix_wr.sel   = rtps_pkg::color_sel_type'(req_tdata[7:6]);
   assign pix_wr.value = req_tdata[15:8];

   rtps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .tick        (tick),
      .pause_ticks (pause_ticks_ff),
      .latch       (latch),
      .slice       (slice),
      .phase       (phase)
   );

   for (genvar g = 0; g < LINES; g++) begin : g_cell
      rtps_cell #(.CELL_ID(g)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .pix_wr (pix_wr),
         .latch  (latch),
         .slice  (slice),
         .level  (cell_level[g])
      );
   end

   // lines past LINES stay low even when inverted
   always_comb begin
      for (int n = 0; n < rtps_pkg::LEVEL_W; n++) begin
         if (n < LINES)
            levels[n] = cell_level[n] ^ invert_ff;
         else
            levels[n] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (tick)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         pause_ticks_ff <= 8'(rtps_pkg::PAUSE_RESET);
         invert_ff      <= 1'b1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rtps_pkg::CSR_PAUSE_TICKS: pause_ticks_ff <= csr_data;
               rtps_pkg::CSR_LINE_INVERT: invert_ff      <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         rsp_data_ff  <= levels;
         rsp_phase_ff <= phase;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_phase_ff;

endmodule

>>> tb/tb_rgb_tube_pulse_serializer.sv
`timescale 1ns / 1ps

module tb_rgb_tube_pulse_serializer;

   localparam int LINES = 48;

   typedef struct {
      logic [rtps_pkg::LEVEL_W-1:0] levels;
      rtps_pkg::phase_type          phase;
   } tick_result_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [15:0]        req_tdata  = '0;
   logic               req_tuser  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [47:0]        rsp_tdata;
   logic [1:0]         rsp_tuser;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index  = '0;
   logic [7:0]         csr_data   = '0;

   // tube model state
   logic [rtps_pkg::PIXEL_W-1:0] staged_px  [LINES];
   logic [rtps_pkg::PIXEL_W-1:0] latched_px [LINES];
   rtps_pkg::phase_type          pred_phase;
   logic [7:0]                   pred_count;
   logic [7:0]                   pause_len;
   logic                         invert_lines;

   tick_result_type    expected_ticks[$];
   int                 error_count = 0;
   bit                 quiet       = 1'b0;

   rgb_tube_pulse_serializer #(.LINES(LINES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= 24);
   end

   function automatic void model_reset();
      for (int n = 0; n < LINES; n++) begin
         staged_px[n]  = '0;
         latched_px[n] = '0;
      end
      pred_phase   = rtps_pkg::PH_PAUSE;
      pred_count   = '0;
      pause_len    = 8'(rtps_pkg::PAUSE_RESET);
      invert_lines = 1'b1;
   endfunction

   function automatic void predict_pixel_write(logic [5:0] idx, logic [1:0] sel,
                                               logic [7:0] val);
      if (idx < LINES) begin
         case (rtps_pkg::color_sel_type'(sel))
            rtps_pkg::SEL_RED:   staged_px[idx][7:0]   = val;
            rtps_pkg::SEL_GREEN: staged_px[idx][15:8]  = val;
            rtps_pkg::SEL_BLUE:  staged_px[idx][23:16] = val;
            default: ;
         endcase
      end
   endfunction

   function automatic void predict_tick();
      tick_result_type res;
      logic [7:0]   phase_len;
      logic [1:0]   next_phase;
      logic [7:0]   color_byte;
      int           slot;
      int           bit_no;
      phase_len = (pred_phase == rtps_pkg::PH_PAUSE) ? pause_len
                                                     : 8'(rtps_pkg::COLOR_TICKS);
      if (pred_count == phase_len) begin
         next_phase = pred_phase + 2'd1;
         pred_phase = rtps_pkg::phase_type'(next_phase);
         pred_count = '0;
         // the frame latches as the pause begins
         if (pred_phase == rtps_pkg::PH_PAUSE) begin
            for (int n = 0; n < LINES; n++) latched_px[n] = staged_px[n];
         end
      end
      res.levels = '0;
      res.phase  = pred_phase;
      slot   = int'(pred_count) % rtps_pkg::TICKS_PER_BIT;
      bit_no = (int'(pred_count) / rtps_pkg::TICKS_PER_BIT) & 7;
      if (pred_phase != rtps_pkg::PH_PAUSE) begin
         for (int n = 0; n < LINES; n++) begin
            case (pred_phase)
               rtps_pkg::PH_GREEN: color_byte = latched_px[n][15:8];
               rtps_pkg::PH_RED:   color_byte = latched_px[n][7:0];
               default:            color_byte = latched_px[n][23:16];
            endcase
            if (slot == 0)
               res.levels[n] = 1'b1;
            else if (slot == rtps_pkg::TICKS_PER_BIT - 1)
               res.levels[n] = 1'b0;
            else
               res.levels[n] = color_byte[bit_no];
         end
      end
      if (invert_lines) res.levels = ~res.levels;
      expected_ticks.push_back(res);
      pred_count = pred_count + 8'd1;
   endfunction

   // result checker
   always @(posedge clock) begin
      tick_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_ticks.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result: levels=%h phase=%0d", rsp_tdata, rsp_tuser);
         end else begin
            want = expected_ticks.pop_front();
            if (rsp_tdata !== want.levels || rsp_tuser !== want.phase) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: levels exp=%h got=%h phase exp=%0d got=%0d",
                           want.levels, rsp_tdata, want.phase, rsp_tuser);
            end
         end
      end
   end

   // all driving tasks start and end at a falling edge
   task automatic send_item(input logic func, input logic [5:0] idx,
                            input logic [1:0] sel, input logic [7:0] val);
      while (!quiet && $urandom_range(0, 99) < 24) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = {val, sel, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (func) predict_pixel_write(idx, sel, val);
      else predict_tick();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_tick();
      send_item(1'b0, 6'($urandom), 2'($urandom), 8'($urandom));
   endtask

   // ticks at tick_pct percent, else mostly in-range writes, some to absent lines or the unused selector
   task automatic send_random(input int tick_pct);
      logic [5:0] idx;
      logic [1:0] sel;
      if ($urandom_range(0, 99) < tick_pct) begin
         send_tick();
      end else begin
         idx = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(48, 63))
                                           : 6'($urandom_range(0, LINES - 1));
         sel = ($urandom_range(0, 9) == 0) ? rtps_pkg::SEL_NONE
                                           : 2'($urandom_range(0, 2));
         send_item(1'b1, idx, sel, 8'($urandom));
      end
   endtask

   task automatic send_many(input int count, input int tick_pct);
      repeat (count) send_random(tick_pct);
   endtask

   task automatic run_until_phase(input rtps_pkg::phase_type ph, input int min_count);
      while (!(pred_phase == ph && pred_count >= min_count)) send_random(95);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (expected_ticks.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(input rtps_pkg::csr_index_type idx, input logic [7:0] value);
      wait_drained();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == rtps_pkg::CSR_PAUSE_TICKS) pause_len = value;
      else invert_lines = value[0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_directed();
      send_tick();
      send_tick();
      send_item(1'b1, 6'd0,  rtps_pkg::SEL_RED,   8'hff);
      send_item(1'b1, 6'd0,  rtps_pkg::SEL_GREEN, 8'h00);
      send_item(1'b1, 6'd47, rtps_pkg::SEL_GREEN, 8'h80);
      send_item(1'b1, 6'd47, rtps_pkg::SEL_BLUE,  8'h01);
      send_item(1'b1, 6'd63, rtps_pkg::SEL_RED,   8'h55);
      send_item(1'b1, 6'd48, rtps_pkg::SEL_GREEN, 8'hff);
      send_item(1'b1, 6'd5,  rtps_pkg::SEL_NONE,  8'haa);
      send_item(1'b1, 6'd22, rtps_pkg::SEL_BLUE,  8'h7f);
      send_item(1'b1, 6'd41, rtps_pkg::SEL_RED,   8'h00);
      send_item(1'b1, 6'd1,  rtps_pkg::SEL_GREEN, 8'ha5);
      send_item(1'b1, 6'd31, rtps_pkg::SEL_RED,   8'h5a);
      send_item(1'b1, 6'd16, rtps_pkg::SEL_BLUE,  8'hc3);
      send_tick();
      send_tick();
      send_tick();
   endtask

   task automatic test_default_frames();
      send_many(40, 65);
      // hold the sender until the pipe is empty
      wait_drained();
      send_many(40, 65);
   endtask

   task automatic test_short_pause();
      write_csr(rtps_pkg::CSR_PAUSE_TICKS, 8'd1);
      write_csr(rtps_pkg::CSR_LINE_INVERT, 8'd0);
      quiet = 1'b1;
      send_many(60, 70);
      quiet = 1'b0;
      send_many(40, 70);
   endtask

   task automatic test_long_pause();
      write_csr(rtps_pkg::CSR_LINE_INVERT, 8'd1);
      run_until_phase(rtps_pkg::PH_BLUE, 0);
      write_csr(rtps_pkg::CSR_PAUSE_TICKS, 8'd255);
      run_until_phase(rtps_pkg::PH_GREEN, 3);
   endtask

   task automatic test_zero_pause();
      write_csr(rtps_pkg::CSR_LINE_INVERT, 8'd0);
      write_csr(rtps_pkg::CSR_PAUSE_TICKS, 8'd0);
      run_until_phase(rtps_pkg::PH_BLUE, 0);
      run_until_phase(rtps_pkg::PH_GREEN, 2);
   endtask

   // shrinking the pause below the running count makes the count wrap
   task automatic test_pause_shrink();
      write_csr(rtps_pkg::CSR_PAUSE_TICKS, 8'd30);
      run_until_phase(rtps_pkg::PH_PAUSE, 20);
      write_csr(rtps_pkg::CSR_PAUSE_TICKS, 8'd6);
      write_csr(rtps_pkg::CSR_LINE_INVERT, 8'd1);
      run_until_phase(rtps_pkg::PH_GREEN, 3);
   endtask

   task automatic test_random_settings();
      repeat (4) begin
         write_csr(rtps_pkg::CSR_PAUSE_TICKS, 8'($urandom_range(1, 20)));
         write_csr(rtps_pkg::CSR_LINE_INVERT, 8'($urandom_range(0, 1)));
         send_many(25, 60);
      end
   endtask

   initial begin
      int waited;
      model_reset();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_default_frames();
      test_short_pause();
      test_long_pause();
      test_zero_pause();
      test_pause_shrink();
      test_random_settings();

      req_tvalid = 1'b0;
      waited = 0;
      while (expected_ticks.size() != 0 && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      repeat (5) @(negedge clock);
      if (expected_ticks.size() != 0) begin
         error_count += expected_ticks.size();
         $display("%0d results never arrived", expected_ticks.size());
      end
      if (error_count == 0) begin
         $display("[rgb_tube_pulse_serializer] OK");
      end else begin
         $display("[rgb_tube_pulse_serializer] ERROR");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("[rgb_tube_pulse_serializer] ERROR");
      $finish;
   end

endmodule

>>> rgb_tube_pulse_serializer.f
rtl/rtps_pkg.sv
rtl/rtps_cell.sv
rtl/rtps_ctrl.sv
rtl/rgb_tube_pulse_serializer.sv
tb/tb_rgb_tube_pulse_serializer.sv
